### hdl/lodp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the lock-order deadlock predictor.
// Depends on nothing; all files but lodp_ram import it.
package lodp_pkg;

    localparam int MODE_W = 3;
    localparam int THR_W  = 3;
    localparam int ID_W   = 5;
    localparam int ST_W   = 2;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOCK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNLOCK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_START   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_ID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic dispatch;
        logic sel_id;
        logic cnt_clr;
        logic cnt_inc;
        logic k_clr;
        logic k_inc;
        logic wr_before_destroy;
        logic wr_before_lock;
        logic wr_combo_destroy;
        logic combo_check;
        logic combo_store;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic go_destroy;
        logic go_lock;
        logic blocking;
        logic cnt_end;
        logic cnt_last;
        logic cnt_held;
        logic row_hit;
        logic k_last_combo;
        logic k_next_end;
        logic held_zero;
        logic count_zero;
        logic combo_match;
        logic out_busy;
    } t_stat;

endpackage

### hdl/lodp_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with the request fields.
// Depends on lodp_pkg for the field widths.
interface lodp_req_if import lodp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  thread_id;
    logic [ID_W-1:0]   lock_id;
    logic              blocking;

    modport source(output valid, mode, thread_id, lock_id, blocking, input ready);
    modport sink(input valid, mode, thread_id, lock_id, blocking, output ready);
endinterface

### hdl/lodp_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the result fields.
// Depends on lodp_pkg for the field widths.
interface lodp_rsp_if import lodp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] assigned_id;
    logic            deadlock_predicted;
    logic [ST_W-1:0] status;

    modport source(output valid, assigned_id, deadlock_predicted, status, input ready);
    modport sink(input valid, assigned_id, deadlock_predicted, status, output ready);
endinterface

### hdl/lodp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lodp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/lodp_dp.sv
`timescale 1ns / 1ps
// Datapath: lock tables, before-set and combination memories, counters, result register.
// Depends on lodp_pkg, lodp_req_if, lodp_rsp_if and lodp_ram.
module lodp_dp import lodp_pkg::*; #(
    parameter int NUM_LOCKS       = 32,
    parameter int NUM_THREADS     = 8,
    parameter int COMBOS_PER_LOCK = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lodp_req_if.sink     i_req,
    lodp_rsp_if.source   o_rsp,
    input  t_cmd         i_cmd,
    output t_stat        o_stat
);
    localparam int LW = $clog2(NUM_LOCKS);
    localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int CW = $clog2(COMBOS_PER_LOCK + 1);
    localparam int NW = $clog2(NUM_LOCKS + 1);
    localparam int AW = $clog2(NUM_LOCKS * COMBOS_PER_LOCK);
    localparam int IW = (LW > ID_W) ? LW : ID_W;
    localparam int XW = (TW > THR_W) ? TW : THR_W;

    logic [MODE_W-1:0]    r_mode;
    logic [THR_W-1:0]     r_thr;
    logic [ID_W-1:0]      r_id;
    logic                 r_blk;
    logic [NUM_LOCKS-1:0] r_held;
    logic [NW-1:0]        r_cnt;
    logic [CW-1:0]        r_k;
    logic                 r_dead;
    logic [ST_W-1:0]      r_status;
    logic [ID_W-1:0]      r_assigned;
    logic                 r_bvq;

    logic [NUM_LOCKS-1:0] r_in_use;
    logic [NUM_LOCKS-1:0] r_held_thr [NUM_THREADS];
    logic [CW-1:0]        r_count [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] r_bvalid;

    logic                 r_ovalid;
    logic [ID_W-1:0]      r_o_id;
    logic                 r_o_dead;
    logic [ST_W-1:0]      r_o_status;

    logic [IW-1:0]        id_ext;
    logic [LW-1:0]        idx;
    logic [XW-1:0]        thr_ext;
    logic [TW-1:0]        tdx;
    logic                 id_ok;
    logic                 thr_ok;
    logic [NUM_LOCKS-1:0] tb;
    logic [NUM_LOCKS-1:0] held_cur;
    logic [NUM_LOCKS-1:0] free_mask;
    logic [LW-1:0]        first_free;
    logic [IW-1:0]        ff_ext;
    logic                 bad;
    logic [LW-1:0]        row;
    logic [CW-1:0]        n_row;
    logic                 full;
    logic [NUM_LOCKS-1:0] b_rd;
    logic [NUM_LOCKS-1:0] rowdata;
    logic                 b_we;
    logic [NUM_LOCKS-1:0] b_wdata;
    logic [NUM_LOCKS-1:0] c_rd;
    logic                 c_we;
    logic [AW-1:0]        c_raddr;
    logic [AW-1:0]        c_waddr;
    logic [NUM_LOCKS-1:0] c_wdata;
    logic                 accept;

    assign id_ext   = IW'(r_id);
    assign idx      = id_ext[LW-1:0];
    assign thr_ext  = XW'(r_thr);
    assign tdx      = thr_ext[TW-1:0];
    assign id_ok    = int'(r_id) < NUM_LOCKS;
    assign thr_ok   = int'(r_thr) < NUM_THREADS;
    assign tb       = {{(NUM_LOCKS-1){1'b0}}, 1'b1} << idx;
    assign held_cur = r_held_thr[tdx];
    assign free_mask = ~r_in_use;

    always_comb begin
        first_free = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                first_free = LW'(i);
            end
        end
    end
    assign ff_ext = IW'(first_free);

    always_comb begin
        unique case (r_mode)
            MODE_CREATE:  bad = 1'b0;
            MODE_DESTROY: bad = !id_ok || !r_in_use[idx];
            MODE_LOCK:    bad = !thr_ok || !id_ok || !r_in_use[idx];
            MODE_UNLOCK:  bad = !thr_ok || !id_ok || !held_cur[idx];
            MODE_START:   bad = !thr_ok;
            default:      bad = 1'b1;
        endcase
    end

    assign row     = i_cmd.sel_id ? idx : r_cnt[LW-1:0];
    assign n_row   = r_count[row];
    assign full    = int'(n_row) >= COMBOS_PER_LOCK;
    assign rowdata = r_bvq ? b_rd : '0;

    assign b_we    = i_cmd.wr_before_destroy || i_cmd.wr_before_lock;
    assign b_wdata = i_cmd.wr_before_lock ? (rowdata | r_held) :
                     (row == idx) ? '0 : (rowdata & ~tb);

    assign c_raddr = AW'(int'(row) * COMBOS_PER_LOCK + int'(r_k));
    assign c_waddr = i_cmd.combo_store ? AW'(int'(row) * COMBOS_PER_LOCK + int'(n_row))
                                       : c_raddr;
    assign c_we    = i_cmd.wr_combo_destroy || (i_cmd.combo_store && !full);
    assign c_wdata = i_cmd.combo_store ? r_held : (c_rd & ~tb);

    lodp_ram #(.WIDTH(NUM_LOCKS), .DEPTH(NUM_LOCKS)) u_before_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (row),
        .i_wdata (b_wdata),
        .i_raddr (row),
        .o_rdata (b_rd)
    );

    lodp_ram #(.WIDTH(NUM_LOCKS), .DEPTH(NUM_LOCKS * COMBOS_PER_LOCK)) u_combo_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rd)
    );

    assign accept = i_req.valid && i_cmd.in_ready;

    always_comb begin
        o_stat.go_destroy   = (r_mode == MODE_DESTROY) && !bad;
        o_stat.go_lock      = (r_mode == MODE_LOCK) && !bad;
        o_stat.blocking     = r_blk;
        o_stat.cnt_end      = int'(r_cnt) == NUM_LOCKS;
        o_stat.cnt_last     = int'(r_cnt) == NUM_LOCKS - 1;
        o_stat.cnt_held     = r_held[r_cnt[LW-1:0]];
        o_stat.row_hit      = ((rowdata & tb) != '0) && (n_row != '0);
        o_stat.k_last_combo = int'(r_k) == COMBOS_PER_LOCK - 1;
        o_stat.k_next_end   = int'(r_k) + 1 >= int'(n_row);
        o_stat.held_zero    = r_held == '0;
        o_stat.count_zero   = n_row == '0;
        o_stat.combo_match  = c_rd == r_held;
        o_stat.out_busy     = r_ovalid && !o_rsp.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_bvalid <= '0;
            r_ovalid <= 1'b0;
            for (int t = 0; t < NUM_THREADS; t++) begin
                r_held_thr[t] <= '0;
            end
            for (int l = 0; l < NUM_LOCKS; l++) begin
                r_count[l] <= '0;
            end
        end else begin
            if (i_cmd.dispatch && !bad) begin
                unique case (r_mode)
                    MODE_CREATE: begin
                        if (free_mask != '0) begin
                            r_in_use[first_free] <= 1'b1;
                        end
                    end
                    MODE_DESTROY: begin
                        r_in_use <= r_in_use & ~tb;
                        r_count[idx] <= '0;
                        for (int t = 0; t < NUM_THREADS; t++) begin
                            r_held_thr[t] <= r_held_thr[t] & ~tb;
                        end
                    end
                    MODE_LOCK:   r_held_thr[tdx] <= held_cur | tb;
                    MODE_UNLOCK: r_held_thr[tdx] <= held_cur & ~tb;
                    MODE_START:  r_held_thr[tdx] <= '0;
                    default: begin
                    end
                endcase
            end
            if (b_we) begin
                r_bvalid[row] <= 1'b1;
            end
            if (i_cmd.combo_store && !full) begin
                r_count[row] <= n_row + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_req.mode;
            r_thr  <= i_req.thread_id;
            r_id   <= i_req.lock_id;
            r_blk  <= i_req.blocking;
        end
        r_bvq <= r_bvalid[row];
        if (i_cmd.dispatch) begin
            r_held     <= held_cur;
            r_dead     <= 1'b0;
            r_assigned <= '0;
            if (bad) begin
                r_status <= ST_BAD;
            end else if (r_mode == MODE_CREATE && free_mask == '0) begin
                r_status <= ST_NO_ID;
            end else begin
                r_status <= ST_OK;
                if (r_mode == MODE_CREATE) begin
                    r_assigned <= ff_ext[ID_W-1:0];
                end
            end
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + NW'(1);
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.combo_check && ((c_rd & tb) != '0) && ((c_rd & r_held) == '0)) begin
            r_dead <= 1'b1;
        end
        if (i_cmd.combo_store && full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.out_load) begin
            r_o_id     <= r_assigned;
            r_o_dead   <= r_dead;
            r_o_status <= r_status;
        end
    end

    assign i_req.ready              = i_cmd.in_ready;
    assign o_rsp.valid              = r_ovalid;
    assign o_rsp.assigned_id        = r_o_id;
    assign o_rsp.deadlock_predicted = r_o_dead;
    assign o_rsp.status             = r_o_status;
endmodule

### hdl/lodp_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences each request through the datapath by commands.
// Depends on lodp_pkg.
module lodp_ctrl import lodp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DR_A, S_DR_B, S_CR_A, S_CR_B, S_PL_CHK, S_PL_ROW,
        S_PC_A, S_PC_B, S_BF_A, S_BF_B, S_SC_A, S_SC_B, S_SC_DEC, S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.dispatch = 1'b1;
                o_cmd.cnt_clr  = 1'b1;
                o_cmd.k_clr    = 1'b1;
                if (i_stat.go_destroy) begin
                    n_state = S_DR_A;
                end else if (i_stat.go_lock && i_stat.blocking) begin
                    n_state = S_PL_CHK;
                end else if (i_stat.go_lock) begin
                    n_state = S_BF_A;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DR_A: n_state = S_DR_B;
            S_DR_B: begin
                o_cmd.wr_before_destroy = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_CR_A;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_DR_A;
                end
            end
            S_CR_A: n_state = S_CR_B;
            S_CR_B: begin
                o_cmd.wr_combo_destroy = 1'b1;
                if (i_stat.k_last_combo) begin
                    o_cmd.k_clr = 1'b1;
                    if (i_stat.cnt_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state = S_CR_A;
                    end
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_CR_A;
                end
            end
            S_PL_CHK: begin
                if (i_stat.cnt_end) begin
                    n_state = S_BF_A;
                end else if (!i_stat.cnt_held) begin
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    n_state = S_PL_ROW;
                end
            end
            S_PL_ROW: begin
                if (i_stat.row_hit) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_PC_A;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_PL_CHK;
                end
            end
            S_PC_A: n_state = S_PC_B;
            S_PC_B: begin
                o_cmd.combo_check = 1'b1;
                if (i_stat.k_next_end) begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_PL_CHK;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_PC_A;
                end
            end
            S_BF_A: begin
                o_cmd.sel_id = 1'b1;
                n_state = S_BF_B;
            end
            S_BF_B: begin
                o_cmd.sel_id = 1'b1;
                o_cmd.wr_before_lock = 1'b1;
                if (i_stat.blocking && !i_stat.held_zero) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = i_stat.count_zero ? S_SC_DEC : S_SC_A;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SC_A: begin
                o_cmd.sel_id = 1'b1;
                n_state = S_SC_B;
            end
            S_SC_B: begin
                o_cmd.sel_id = 1'b1;
                if (i_stat.combo_match) begin
                    n_state = S_FINISH;
                end else if (i_stat.k_next_end) begin
                    n_state = S_SC_DEC;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_SC_A;
                end
            end
            S_SC_DEC: begin
                o_cmd.sel_id = 1'b1;
                o_cmd.combo_store = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### hdl/lock_order_deadlock_predictor_core.sv
`timescale 1ns / 1ps
// Lock-order deadlock predictor top level: controller plus datapath.
// Depends on lodp_pkg, the two channel interfaces, lodp_ctrl and lodp_dp.
//
// Requests arrive on i_req (valid/ready); one result leaves on o_rsp per request.
// A transfer happens at a rising edge where valid and ready are both high.
// The block handles one request at a time; i_req.ready is high only when idle.
// Create, unlock, thread start and rejected requests go straight to the result.
// A try-lock updates the target's before-set row; a blocking lock first scans
// every lock number, reads the row of each held predecessor, checks each stored
// combination of a predecessor whose row holds the target, and searches the
// stored combinations of the target, all through the one read port of each of
// the two memories. A destroy sweeps every entry of both memories in turn.
// The result sits in an output register; while the receiver stalls, the block
// finishes the next request's work and then waits to load its result.
// Reset is synchronous and active low; it clears all lock tables at once
// through per-row valid bits, so no clearing pass is needed.
module lock_order_deadlock_predictor_core import lodp_pkg::*; #(
    parameter int NUM_LOCKS       = 32,
    parameter int NUM_THREADS     = 8,
    parameter int COMBOS_PER_LOCK = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lodp_req_if.sink   i_req,
    lodp_rsp_if.source o_rsp
);
    t_cmd  cmd;
    t_stat stat;

    lodp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lodp_dp #(
        .NUM_LOCKS       (NUM_LOCKS),
        .NUM_THREADS     (NUM_THREADS),
        .COMBOS_PER_LOCK (COMBOS_PER_LOCK)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule
